FILE: hw/rtl/reflector_cluster_detector_unit_assert.svh
// Assertion macros shared by the checker of the reflector cluster detector.
// No dependencies; included by the checker file.
`ifndef REFLECTOR_CLUSTER_DETECTOR_UNIT_ASSERT_SVH
`define REFLECTOR_CLUSTER_DETECTOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rcd_pkg.sv
// Shared constants, types and helper functions of the reflector cluster detector.
// No dependencies; the squaring unit, divider, top level and checker import this package.
package rcd_pkg;

    localparam int COORD_BITS      = 20;
    localparam int MAX_SCAN_POINTS = 2048;
    localparam int REG_BITS        = 16;
    localparam int INT_BITS        = 16;
    localparam int OUT_CNT_BITS    = 12;

    localparam int CNT_BITS        = $clog2(MAX_SCAN_POINTS + 1);
    localparam int SUM_BITS        = COORD_BITS + CNT_BITS;
    localparam int DIFF_BITS       = COORD_BITS + 1;
    localparam int ACC_BITS        = 2 * REG_BITS + 3;
    localparam int BIT_IDX_BITS    = $clog2(REG_BITS);
    localparam int DIV_CNT_BITS    = $clog2(SUM_BITS);

    localparam int IN_FIELD_BITS   = 2 * COORD_BITS + INT_BITS;
    localparam int IN_DATA_BITS    = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS  = 2 * COORD_BITS + OUT_CNT_BITS;
    localparam int OUT_DATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_ADDR_BITS   = 2;

    localparam logic [CFG_ADDR_BITS-1:0] REG_INTENSITY_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_NEIGHBOR_GAP_MM     = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_LENGTH_MM       = 2'd2;

    localparam logic [REG_BITS-1:0] RST_INTENSITY_THRESHOLD = 16'd1000;
    localparam logic [REG_BITS-1:0] RST_NEIGHBOR_GAP_MM     = 16'd100;
    localparam logic [REG_BITS-1:0] RST_MIN_LENGTH_MM       = 16'd50;

    // Operand phases of the squaring unit: plus a squared, plus b squared, minus c squared.
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    typedef struct packed {
        logic done;
        logic neg;
        logic pos;
    } t_sq_res;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EVAL  = 8'b0000_0010,
        S_DIST  = 8'b0000_0100,
        S_CLOSE = 8'b0000_1000,
        S_SPAN  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    function automatic logic [DIFF_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic [DIFF_BITS-1:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return d[DIFF_BITS-1] ? (~d + 1'b1) : d;
    endfunction

endpackage

FILE: hw/rtl/rcd_sqsum.sv
// Bit-serial shift-add unit that evaluates a*a + b*b - c*c and reports its sign.
// Depends on rcd_pkg.
module rcd_sqsum
    import rcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [REG_BITS-1:0] i_op_a,
    input  logic [REG_BITS-1:0] i_op_b,
    input  logic [REG_BITS-1:0] i_op_c,
    output t_sq_res             o_res
);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [1:0]              r_phase, n_phase;
    logic [BIT_IDX_BITS-1:0] r_bit, n_bit;
    logic [ACC_BITS-1:0]     r_acc, n_acc;
    logic [ACC_BITS-1:0]     r_mcand, n_mcand;
    logic [REG_BITS-1:0]     r_mplier, n_mplier;
    logic [REG_BITS-1:0]     r_op_b, n_op_b;
    logic [REG_BITS-1:0]     r_op_c, n_op_c;

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_op_b   = r_op_b;
        n_op_c   = r_op_c;
        if (i_start) begin
            n_busy   = 1'b1;
            n_phase  = PH_A;
            n_bit    = '0;
            n_acc    = '0;
            n_mcand  = ACC_BITS'(i_op_a);
            n_mplier = i_op_a;
            n_op_b   = i_op_b;
            n_op_c   = i_op_c;
        end else if (r_busy) begin
            // One multiplier bit per cycle; the third operand is subtracted.
            if (r_mplier[0]) begin
                n_acc = (r_phase == PH_C) ? (r_acc - r_mcand) : (r_acc + r_mcand);
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            if (r_bit == BIT_IDX_BITS'(REG_BITS - 1)) begin
                n_bit = '0;
                unique case (r_phase)
                    PH_A: begin
                        n_phase  = PH_B;
                        n_mcand  = ACC_BITS'(r_op_b);
                        n_mplier = r_op_b;
                    end
                    PH_B: begin
                        n_phase  = PH_C;
                        n_mcand  = ACC_BITS'(r_op_c);
                        n_mplier = r_op_c;
                    end
                    PH_C: begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                    default: begin
                        n_busy = 1'b0;
                    end
                endcase
            end else begin
                n_bit = r_bit + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase  <= n_phase;
        r_bit    <= n_bit;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_op_b   <= n_op_b;
        r_op_c   <= n_op_c;
    end

    assign o_res.done = r_done;
    assign o_res.neg  = r_acc[ACC_BITS-1];
    assign o_res.pos  = !r_acc[ACC_BITS-1] && (|r_acc);

endmodule

FILE: hw/rtl/rcd_div.sv
// Restoring divider, one quotient bit per cycle, truncating a signed sum by a count.
// Depends on rcd_pkg.
module rcd_div
    import rcd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [SUM_BITS-1:0]   i_dividend,
    input  logic [CNT_BITS-1:0]          i_divisor,
    output logic                         o_done,
    output logic [COORD_BITS-1:0]        o_quot
);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                    r_neg, n_neg;
    logic [SUM_BITS-1:0]     r_q, n_q;
    logic [CNT_BITS-1:0]     r_rem, n_rem;
    logic [CNT_BITS-1:0]     r_dsr, n_dsr;

    logic [SUM_BITS-1:0]     w_mag;
    logic [CNT_BITS:0]       w_trial;
    logic [SUM_BITS-1:0]     w_q_signed;

    assign w_mag   = i_dividend[SUM_BITS-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_trial = {r_rem, r_q[SUM_BITS-1]} - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_dividend[SUM_BITS-1];
            n_q    = w_mag;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (!w_trial[CNT_BITS]) begin
                n_rem = w_trial[CNT_BITS-1:0];
                n_q   = {r_q[SUM_BITS-2:0], 1'b1};
            end else begin
                // The partial remainder stays below the divisor, so it still fits.
                n_rem = {r_rem[CNT_BITS-2:0], r_q[SUM_BITS-1]};
                n_q   = {r_q[SUM_BITS-2:0], 1'b0};
            end
            if (r_cnt == DIV_CNT_BITS'(SUM_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    // Negating the magnitude quotient gives truncation towards zero.
    assign w_q_signed = r_neg ? (~r_q + 1'b1) : r_q;
    assign o_quot     = w_q_signed[COORD_BITS-1:0];
    assign o_done     = r_done;

endmodule

FILE: hw/rtl/reflector_cluster_detector_unit.sv
// Reflector cluster detector: groups bright lidar points into clusters and reports centroids.
// Depends on rcd_pkg, rcd_sqsum and rcd_div.
//
// One point is taken per input transfer and the block then works on it alone: a dim point
// without end of scan passes S_EVAL only, a bright point checked against its neighbour also
// waits in S_DIST for the squaring unit, and a point that closes a reported cluster goes on
// through S_CLOSE, S_SPAN, S_DIV, S_EMIT and S_FIN, held in S_EMIT only while the previous
// result still waits in the output register. The shift-add squaring unit takes one bit of
// one of its three operands per cycle, then hands over its sign for each spacing or span
// check; the two restoring dividers form the centroid, one quotient bit per cycle. Clear
// spans that exceed the minimum length in x or y skip the squaring pass. A finished result
// sits in an output register; the next point is accepted while it waits.
module reflector_cluster_detector_unit
    import rcd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input stream.
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // point_x, point_y, intensity (from bit 0 up)
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    // end_of_scan
    input  logic                     i_s_tlast,
    // Result stream.
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // mean_x, mean_y, cluster_points, zero padding (from bit 0 up)
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,
    // Configuration write port.
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [REG_BITS-1:0]      i_cfg_wdata
);

    t_state r_state, n_state;

    logic [REG_BITS-1:0] r_thr, r_gap, r_min;

    logic signed [COORD_BITS-1:0] r_x, n_x, r_y, n_y;
    logic [INT_BITS-1:0]          r_inten, n_inten;
    logic                         r_eos, n_eos;
    logic                         r_brk, n_brk;

    logic                         r_open, n_open;
    logic signed [COORD_BITS-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic signed [COORD_BITS-1:0] r_last_x, n_last_x, r_last_y, n_last_y;
    logic signed [SUM_BITS-1:0]   r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic [CNT_BITS-1:0]          r_count, n_count;

    logic                     r_out_valid, n_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data, n_out_data;

    logic [DIFF_BITS-1:0] w_dx, w_dy, w_sx, w_sy;
    logic                 w_bright, w_near_ok, w_full, w_span_far;
    logic                 w_sq_start, w_div_start;
    logic [REG_BITS-1:0]  w_op_a, w_op_b, w_op_c;
    t_sq_res              w_sq;
    logic                 w_div_done_x, w_div_done_y;
    logic [COORD_BITS-1:0] w_qx, w_qy;

    assign w_bright   = r_inten > r_thr;
    assign w_dx       = abs_diff(r_x, r_last_x);
    assign w_dy       = abs_diff(r_y, r_last_y);
    assign w_near_ok  = (w_dx < DIFF_BITS'(r_gap)) && (w_dy < DIFF_BITS'(r_gap));
    assign w_full     = r_count >= CNT_BITS'(MAX_SCAN_POINTS);
    assign w_sx       = abs_diff(r_first_x, r_last_x);
    assign w_sy       = abs_diff(r_first_y, r_last_y);
    assign w_span_far = (w_sx > DIFF_BITS'(r_min)) || (w_sy > DIFF_BITS'(r_min));

    // Both checks reach the squaring unit only once each difference fits a register width.
    assign w_op_a = (r_state == S_EVAL) ? w_dx[REG_BITS-1:0] : w_sx[REG_BITS-1:0];
    assign w_op_b = (r_state == S_EVAL) ? w_dy[REG_BITS-1:0] : w_sy[REG_BITS-1:0];
    assign w_op_c = (r_state == S_EVAL) ? r_gap : r_min;

    rcd_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .i_op_c  (w_op_c),
        .o_res   (w_sq)
    );

    rcd_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum_x),
        .i_divisor  (r_count),
        .o_done     (w_div_done_x),
        .o_quot     (w_qx)
    );

    rcd_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum_y),
        .i_divisor  (r_count),
        .o_done     (w_div_done_y),
        .o_quot     (w_qy)
    );

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_inten     = r_inten;
        n_eos       = r_eos;
        n_brk       = r_brk;
        n_open      = r_open;
        n_first_x   = r_first_x;
        n_first_y   = r_first_y;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_count     = r_count;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_m_tready;
        w_sq_start  = 1'b0;
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_x     = i_s_tdata[COORD_BITS-1:0];
                    n_y     = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
                    n_inten = i_s_tdata[IN_FIELD_BITS-1:2*COORD_BITS];
                    n_eos   = i_s_tlast;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_brk = 1'b0;
                if (!w_bright) begin
                    n_state = r_eos ? S_CLOSE : S_IDLE;
                end else if (!r_open) begin
                    // A single point closed by end of scan is never reported.
                    n_open    = !r_eos;
                    n_first_x = r_x;
                    n_first_y = r_y;
                    n_last_x  = r_x;
                    n_last_y  = r_y;
                    n_sum_x   = SUM_BITS'(r_x);
                    n_sum_y   = SUM_BITS'(r_y);
                    n_count   = CNT_BITS'(1);
                    n_state   = S_IDLE;
                end else if (w_full || !w_near_ok) begin
                    n_brk   = 1'b1;
                    n_state = S_CLOSE;
                end else begin
                    w_sq_start = 1'b1;
                    n_state    = S_DIST;
                end
            end
            S_DIST: begin
                if (w_sq.done) begin
                    if (w_sq.neg) begin
                        n_last_x = r_x;
                        n_last_y = r_y;
                        n_sum_x  = r_sum_x + SUM_BITS'(r_x);
                        n_sum_y  = r_sum_y + SUM_BITS'(r_y);
                        n_count  = r_count + 1'b1;
                        n_state  = r_eos ? S_CLOSE : S_IDLE;
                    end else begin
                        // An equal spacing counts as a break.
                        n_brk   = 1'b1;
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                if (!r_open || (r_count < CNT_BITS'(2))) begin
                    n_state = S_FIN;
                end else if (w_span_far) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    w_sq_start = 1'b1;
                    n_state    = S_SPAN;
                end
            end
            S_SPAN: begin
                if (w_sq.done) begin
                    if (w_sq.pos) begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done_x && w_div_done_y) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_data  = OUT_DATA_BITS'({OUT_CNT_BITS'(r_count), w_qy, w_qx});
                    n_out_valid = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_FIN: begin
                n_open = 1'b0;
                if (r_brk) begin
                    // The breaking point opens a new cluster unless the scan ends here.
                    n_open    = !r_eos;
                    n_first_x = r_x;
                    n_first_y = r_y;
                    n_last_x  = r_x;
                    n_last_y  = r_y;
                    n_sum_x   = SUM_BITS'(r_x);
                    n_sum_y   = SUM_BITS'(r_y);
                    n_count   = CNT_BITS'(1);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= RST_INTENSITY_THRESHOLD;
            r_gap       <= RST_NEIGHBOR_GAP_MM;
            r_min       <= RST_MIN_LENGTH_MM;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_INTENSITY_THRESHOLD: r_thr <= i_cfg_wdata;
                    REG_NEIGHBOR_GAP_MM:     r_gap <= i_cfg_wdata;
                    REG_MIN_LENGTH_MM:       r_min <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_inten    <= n_inten;
        r_eos      <= n_eos;
        r_brk      <= n_brk;
        r_first_x  <= n_first_x;
        r_first_y  <= n_first_y;
        r_last_x   <= n_last_x;
        r_last_y   <= n_last_y;
        r_sum_x    <= n_sum_x;
        r_sum_y    <= n_sum_y;
        r_count    <= n_count;
        r_out_data <= n_out_data;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: hw/rtl/rcd_checker.sv
// Port-level checker for the reflector cluster detector, bound to the top level.
// Depends on rcd_pkg and reflector_cluster_detector_unit_assert.svh.
`include "reflector_cluster_detector_unit_assert.svh"

module rcd_checker
    import rcd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_tvalid,
    input logic                     o_s_tready,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [OUT_DATA_BITS-1:0] o_m_tdata
);

    // A result waiting for the consumer keeps its contents.
    `RCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")

    // A reported cluster always holds at least two points.
    `RCD_ASSERT_SAME(a_min_points, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[OUT_FIELD_BITS-1:2*COORD_BITS] >= OUT_CNT_BITS'(2), "cluster reported with fewer than two points")

    // Points are handled one at a time: no transfer directly after another.
    `RCD_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "input accepted on consecutive cycles")

    // A new result needs at least the evaluation cycle after a transfer.
    `RCD_ASSERT_SAME(a_no_instant_result, i_clk, i_rst_n, $rose(o_m_tvalid), !$past(i_s_tvalid && o_s_tready), "result appeared straight after an input transfer")

endmodule

bind reflector_cluster_detector_unit rcd_checker u_rcd_checker (.*);
